/* hdl/tdpc_pkg.sv */
// ----------------------------------------------------------------------------
// tdpc_pkg: shared constants and types of the trial division prime counter
// Default number width, total width and remainder unit status.
// ----------------------------------------------------------------------------
package tdpc_pkg;

    localparam int NUMBER_BITS_DEF = 20;
    localparam int TOTAL_BITS      = 32;

    // status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

/* hdl/tdpc_if.sv */
// ----------------------------------------------------------------------------
// tdpc interfaces: range request channel and result channel
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tdpc_range_if #(
    parameter int NUMBER_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS-1:0] range_start;
    logic [NUMBER_BITS:0]   range_end;

    modport source (output valid, output range_start, output range_end, input ready);
    modport sink   (input valid, input range_start, input range_end, output ready);
endinterface

interface tdpc_result_if #(
    parameter int NUMBER_BITS = 20,
    parameter int TOTAL_BITS  = 32
);
    logic                   valid;
    logic                   ready;
    logic [NUMBER_BITS:0]   range_primes;
    logic [TOTAL_BITS-1:0]  total_primes;

    modport source (output valid, output range_primes, output total_primes, input ready);
    modport sink   (input valid, input range_primes, input total_primes, output ready);
endinterface

/* hdl/tdpc_rem.sv */
// ----------------------------------------------------------------------------
// tdpc_rem: bit-serial remainder unit
// Restoring shift-subtract, one dividend bit per cycle; flags zero remainder.
// ----------------------------------------------------------------------------
module tdpc_rem
    import tdpc_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF,
    parameter int DIV_BITS    = NUMBER_BITS / 2 + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUMBER_BITS-1:0] dividend,
    input  logic [DIV_BITS-1:0]    divisor,
    output rem_status_t            status
);

    localparam int CNT_BITS = $clog2(NUMBER_BITS + 1);

    logic [NUMBER_BITS-1:0] dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]    rem_reg, rem_next;
    logic [DIV_BITS-1:0]    dsr_reg, dsr_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIV_BITS:0]      trial;
    logic [DIV_BITS:0]      diff;

    assign trial = {rem_reg, dvd_reg[NUMBER_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CNT_BITS'(NUMBER_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the low bits hold it
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[DIV_BITS-1:0];
            else
                rem_next = trial[DIV_BITS-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

/* hdl/trial_division_prime_counter.sv */
// Each number is tested in ST_TEST; one below 4 or even is settled there. An
// odd n >= 5 alternates ST_CHECK and ST_DIV over the odd divisors tried (at
// most sqrt(n)/2) in the bit-serial remainder unit. One range at a time: the
// next request is taken once the current range is done and its result is
// registered. Reset (rst_n, async, active low) clears the total and all control.
// ----------------------------------------------------------------------------
// trial_division_prime_counter: counts primes in [range_start, range_end)
// Sequencer walks the numbers of the range and, for each odd candidate of 5 or
// more, drives a shared remainder unit over odd divisors d with d*d <= n.
// ----------------------------------------------------------------------------
module trial_division_prime_counter
    import tdpc_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    tdpc_range_if.sink    ranges,
    tdpc_result_if.source counts
);

    // divisor width covers the first odd d with d*d above any NUMBER_BITS value
    localparam int DIV_BITS = NUMBER_BITS / 2 + 2;
    localparam int SQ_BITS  = 2 * DIV_BITS;
    localparam logic [NUMBER_BITS:0] LIMIT = {1'b1, {NUMBER_BITS{1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t                state_reg, state_next;
    logic [NUMBER_BITS:0]  n_reg, n_next;        // current candidate
    logic [NUMBER_BITS:0]  hi_reg, hi_next;      // exclusive end, clamped
    logic [NUMBER_BITS:0]  count_reg, count_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;        // trial divisor, odd
    logic [SQ_BITS-1:0]    sq_reg, sq_next;      // d*d, kept incrementally
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  ovalid_reg, ovalid_next;
    logic [NUMBER_BITS:0]  oprimes_reg, oprimes_next;
    logic [TOTAL_BITS-1:0] ototal_reg, ototal_next;

    logic                  rem_start;
    rem_status_t           rem_stat;
    logic [TOTAL_BITS:0]   sum;
    logic [SQ_BITS-1:0]    sq_step;

    tdpc_rem #(
        .NUMBER_BITS (NUMBER_BITS),
        .DIV_BITS    (DIV_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg[NUMBER_BITS-1:0]),
        .divisor  (d_reg),
        .status   (rem_stat)
    );

    // saturating total; count fits well inside 33 bits
    assign sum = {1'b0, total_reg} + (TOTAL_BITS+1)'(count_reg);

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_step = (SQ_BITS'(d_reg) << 2) + SQ_BITS'(4);

    assign ranges.ready       = (state_reg == ST_IDLE);
    assign counts.valid        = ovalid_reg;
    assign counts.range_primes = oprimes_reg;
    assign counts.total_primes = ototal_reg;

    always_comb
    begin
        state_next   = state_reg;
        n_next       = n_reg;
        hi_next      = hi_reg;
        count_next   = count_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        total_next   = total_reg;
        ovalid_next  = ovalid_reg;
        oprimes_next = oprimes_reg;
        ototal_next  = ototal_reg;
        rem_start    = 1'b0;

        // result register drains independently of the sequencer
        if (ovalid_reg && counts.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (ranges.valid)
                begin
                    n_next     = {1'b0, ranges.range_start};
                    hi_next    = (ranges.range_end > LIMIT) ? LIMIT : ranges.range_end;
                    count_next = '0;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (n_reg >= hi_reg)
                    state_next = ST_FINISH;
                else if (n_reg < (NUMBER_BITS+1)'(2))
                    n_next = n_reg + 1'b1;
                else if (n_reg < (NUMBER_BITS+1)'(4))
                begin
                    // two and three are prime
                    count_next = count_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                end
                else if (!n_reg[0])
                    n_next = n_reg + 1'b1;
                else
                begin
                    d_next     = DIV_BITS'(3);
                    sq_next    = SQ_BITS'(9);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > SQ_BITS'(n_reg))
                begin
                    // no divisor up to the square root: prime
                    count_next = count_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = ST_TEST;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_TEST;
                    end
                    else
                    begin
                        d_next     = d_reg + DIV_BITS'(2);
                        sq_next    = sq_reg + sq_step;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH:
            begin
                // wait for the result register to be free
                if (!ovalid_reg || counts.ready)
                begin
                    total_next   = sum[TOTAL_BITS] ? '1 : sum[TOTAL_BITS-1:0];
                    ovalid_next  = 1'b1;
                    oprimes_next = count_reg;
                    ototal_next  = total_next;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            total_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        hi_reg      <= hi_next;
        count_reg   <= count_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        oprimes_reg <= oprimes_next;
        ototal_reg  <= ototal_next;
    end

endmodule
